@@ rtl/mfr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfr_pkg
// shared types, constants and codes of the meter frame receiver
// ----------------------------------------------------------------------------
package mfr_pkg;

    localparam logic [7:0] START_BYTE   = 8'h68;
    localparam logic [7:0] DATA_OFFSET  = 8'h33;
    localparam int         ADDR_BYTES   = 6;
    localparam int         ADDR_W       = 8 * ADDR_BYTES;
    localparam int         COUNT_W      = 9;
    localparam logic [COUNT_W-1:0] ID_LEN_1997 = 9'd2;
    localparam logic [COUNT_W-1:0] ID_LEN_2007 = 9'd4;

    // configuration register indexes
    localparam int         CFG_INDEX_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_PROTOCOL_VARIANT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_DATA_LENGTH  = 8'd1;
    localparam logic [7:0] MIN_LEN_RESET = 8'd2;

    // result kind codes
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // frame status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CHECKSUM  = 2'd1;
    localparam logic [1:0] ST_TOO_SHORT = 2'd2;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_ADDR = 4'b0010,
        PH_HEAD = 4'b0100,
        PH_DATA = 4'b1000
    } t_phase;

    typedef struct packed {
        logic       protocol_variant;
        logic [7:0] min_data_length;
    } t_cfg;

    typedef struct packed {
        logic              kind;
        logic [7:0]        data_value;
        logic              is_identifier;
        logic [ADDR_W-1:0] meter_address;
        logic [7:0]        control_code;
        logic [7:0]        data_length;
        logic [1:0]        frame_status;
    } t_result;

endpackage
`default_nettype wire

@@ rtl/mfr_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfr_parser
// input byte register and per-byte frame state update
// ----------------------------------------------------------------------------
module mfr_parser
    import mfr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg    i_cfg,
    input  wire logic    i_rx_valid,
    input  wire logic    [7:0] i_rx_byte,
    output logic         o_rx_ready,
    input  wire logic    i_room,
    output logic         o_res_valid,
    output t_result      o_res
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    t_phase             r_phase, n_phase;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [7:0]         r_sum, n_sum;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [7:0]         r_ctrl, n_ctrl;
    logic [7:0]         r_len, n_len;
    logic [7:0]         r_csum, n_csum;

    logic               fire;
    logic               accept;
    logic [COUNT_W-1:0] id_len;
    logic [COUNT_W-1:0] len_ext;

    assign fire       = r_in_valid && i_room;
    assign o_rx_ready = !r_in_valid || i_room;
    assign accept     = i_rx_valid && o_rx_ready;
    assign id_len     = i_cfg.protocol_variant ? ID_LEN_2007 : ID_LEN_1997;
    assign len_ext    = {1'b0, r_len};

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_sum   = r_sum;
        n_addr  = r_addr;
        n_ctrl  = r_ctrl;
        n_len   = r_len;
        n_csum  = r_csum;
        o_res_valid          = 1'b0;
        o_res.kind           = KIND_DATA;
        o_res.data_value     = r_in_byte - DATA_OFFSET;
        o_res.is_identifier  = r_count < id_len;
        o_res.meter_address  = r_addr;
        o_res.control_code   = r_ctrl;
        o_res.data_length    = r_len;
        o_res.frame_status   = ST_OK;
        unique case (r_phase)
            PH_HUNT: begin
                if (r_in_byte == START_BYTE) begin
                    n_sum   = START_BYTE;
                    n_count = '0;
                    n_addr  = '0;
                    n_phase = PH_ADDR;
                end
            end
            PH_ADDR: begin
                if (r_count < COUNT_W'(ADDR_BYTES)) begin
                    for (int i = 0; i < ADDR_BYTES; i++) begin
                        if (r_count == COUNT_W'(i)) begin
                            n_addr[8*i +: 8] = r_in_byte;
                        end
                    end
                    n_sum   = r_sum + r_in_byte;
                    n_count = r_count + 1'b1;
                end else if (r_in_byte == START_BYTE) begin
                    n_sum   = r_sum + r_in_byte;
                    n_count = '0;
                    n_phase = PH_HEAD;
                end else begin
                    // wrong second start byte, drop the frame
                    n_count = '0;
                    n_phase = PH_HUNT;
                end
            end
            PH_HEAD: begin
                n_sum = r_sum + r_in_byte;
                if (r_count == '0) begin
                    n_ctrl  = r_in_byte;
                    n_count = COUNT_W'(1);
                end else begin
                    n_len   = r_in_byte;
                    n_count = '0;
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (r_count < len_ext) begin
                    n_sum       = r_sum + r_in_byte;
                    n_count     = r_count + 1'b1;
                    o_res_valid = 1'b1;
                end else if (r_count == len_ext) begin
                    n_csum  = r_in_byte;
                    n_count = r_count + 1'b1;
                end else begin
                    // end byte closes the frame, its value is not checked
                    o_res_valid         = 1'b1;
                    o_res.kind          = KIND_FRAME;
                    o_res.data_value    = '0;
                    o_res.is_identifier = 1'b0;
                    if (r_len < i_cfg.min_data_length) begin
                        o_res.frame_status = ST_TOO_SHORT;
                    end else if (r_csum != r_sum) begin
                        o_res.frame_status = ST_CHECKSUM;
                    end else begin
                        o_res.frame_status = ST_OK;
                    end
                    n_count = '0;
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                n_count = '0;
                n_phase = PH_HUNT;
            end
        endcase
        if (!fire) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_HUNT;
            r_count    <= '0;
            r_sum      <= '0;
            r_addr     <= '0;
            r_ctrl     <= '0;
            r_len      <= '0;
            r_csum     <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_sum   <= n_sum;
                r_addr  <= n_addr;
                r_ctrl  <= n_ctrl;
                r_len   <= n_len;
                r_csum  <= n_csum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // header counter never runs past the control and length bytes
    a_head_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEAD) |-> (r_count <= COUNT_W'(1)))
        else $error("header byte count out of range");

    // address phase counts at most the address bytes
    a_addr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ADDR) |-> (r_count <= COUNT_W'(ADDR_BYTES)))
        else $error("address byte count out of range");

    // a frame result always returns the parser to hunting
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_FRAME) |=> (r_phase == PH_HUNT))
        else $error("frame result without return to hunting");

endmodule
`default_nettype wire

@@ rtl/mfr_out_buf.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfr_out_buf
// result register with a skid stage in front of the output channel
// ----------------------------------------------------------------------------
module mfr_out_buf
    import mfr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    output logic         o_room,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop     = r_main_valid && i_ready;
    assign o_room  = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_res   = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid <= i_res;
            end else begin
                r_main <= i_res;
            end
        end
    end

    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid stage holds a result while output is empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("result pushed with no room");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_main_valid && !i_ready) |=> r_skid_valid)
        else $error("stalled result not kept in skid stage");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (r_main_valid && !r_skid_valid))
        else $error("skid stage did not move to output");

endmodule
`default_nettype wire

@@ rtl/meter_frame_receiver.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// meter_frame_receiver
// byte-wise receiver for two-start-byte meter frames with decoded data output
// ----------------------------------------------------------------------------
// usage
//   rx channel: one received byte per transfer (i_rx_valid / o_rx_ready)
//   cfg channel: register index and data per transfer, always ready;
//     index 0 protocol variant (identifier length 2 or 4), index 1 minimum
//     data length; other indexes are ignored; write only while idle
//   out channel: zero or one result per byte; data bytes come out at once
//     with the offset removed, the end byte gives a frame result with
//     address, control, length and status
//   path: a taken byte is held in the input byte register, decoded by the
//     state update and written to the result register or the skid stage
//   throughput: one byte per cycle while the output stages have room; the
//     state update is combinational between the input and result registers
//   stall: while the output waits, the next result goes to a skid stage;
//     with both output stages full the parser holds its byte, and
//     o_rx_ready drops once a byte sits in the input register
//   reset: synchronous active low; parser returns to hunting for a start
//     byte, output stages empty, protocol variant 0, minimum length 2
// ----------------------------------------------------------------------------
module meter_frame_receiver
    import mfr_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // received bytes
    input  wire logic                   i_rx_valid,
    output logic                        o_rx_ready,
    input  wire logic [7:0]             i_rx_byte,
    // configuration writes
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [7:0]             i_cfg_data,
    // results
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic                        o_result_kind,
    output logic [7:0]                  o_data_value,
    output logic                        o_is_identifier,
    output logic [ADDR_W-1:0]           o_meter_address,
    output logic [7:0]                  o_control_code,
    output logic [7:0]                  o_data_length,
    output logic [1:0]                  o_frame_status
);

    t_cfg    r_cfg;
    logic    room;
    logic    res_valid;
    t_result res;
    t_result out_res;

    // configuration registers, written at any transfer
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.protocol_variant <= 1'b0;
            r_cfg.min_data_length  <= MIN_LEN_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_PROTOCOL_VARIANT) begin
                r_cfg.protocol_variant <= i_cfg_data[0];
            end else if (i_cfg_index == REG_MIN_DATA_LENGTH) begin
                r_cfg.min_data_length <= i_cfg_data;
            end
        end
    end

    // frame state machine, one byte per cycle while the output stages have room
    mfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_rx_valid  (i_rx_valid),
        .i_rx_byte   (i_rx_byte),
        .o_rx_ready  (o_rx_ready),
        .i_room      (room),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register and skid stage
    mfr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_result_kind   = out_res.kind;
    assign o_data_value    = out_res.data_value;
    assign o_is_identifier = out_res.is_identifier;
    assign o_meter_address = out_res.meter_address;
    assign o_control_code  = out_res.control_code;
    assign o_data_length   = out_res.data_length;
    assign o_frame_status  = out_res.frame_status;

endmodule
`default_nettype wire
